[rtl/core/bma_pkg.sv]
// Shared types, constants and the reciprocal table of the mosaic block averager.
// No dependencies; the averaging pipeline and the top level import this package.
package bma_pkg;

   // Default frame limits handed to the top level as parameter defaults.
   localparam int DEF_MAX_WIDTH  = 320;
   localparam int DEF_MAX_HEIGHT = 240;

   // Register field widths and reset values.
   localparam int BLOCK_SIZE_W       = 3;
   localparam int FRAME_WIDTH_W      = 9;
   localparam int FRAME_HEIGHT_W     = 8;
   localparam int BLOCK_SIZE_RESET   = 2;
   localparam int FRAME_WIDTH_RESET  = 320;
   localparam int FRAME_HEIGHT_RESET = 240;
   localparam int MIN_BLOCK          = 2;

   // Register write port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   // Pixel and accumulator widths.
   localparam int PIX_W          = 8;
   localparam int CHANNELS       = 3;
   localparam int SUM_W          = 14;
   localparam int CNT_W          = 6;
   localparam int BLOCK_COLUMN_W = 8;
   localparam int BLOCK_ROW_W    = 7;
   localparam int AVG_MAX        = 255;

   // Division by the qualifying count is a multiply by ceil(2^20 / count).
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // Channel order inside the accumulator word.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // One entry of the block-column accumulator memory.
   typedef struct packed {
      logic [CHANNELS-1:0][SUM_W-1:0] sum;
      logic [CNT_W-1:0]               count;
   } bma_acc_type;

   // A completed block on its way to the averaging pipeline.
   typedef struct packed {
      logic [BLOCK_COLUMN_W-1:0] block_column;
      logic [BLOCK_ROW_W-1:0]    block_row;
      logic                      frame_done;
      bma_acc_type               acc;
   } bma_job_type;

   // One result transaction.
   typedef struct packed {
      logic [BLOCK_COLUMN_W-1:0] block_column;
      logic [BLOCK_ROW_W-1:0]    block_row;
      logic [PIX_W-1:0]          avg_red;
      logic [PIX_W-1:0]          avg_green;
      logic [PIX_W-1:0]          avg_blue;
      logic                      frame_done;
   } bma_result_type;

   // ceil(2^20 / count) for counts 2..63. Counts 0 and 1 take the raw sum instead.
   function automatic logic [RECIP_W-1:0] bma_recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         6'd2:  r = 20'd524288;
         6'd3:  r = 20'd349526;
         6'd4:  r = 20'd262144;
         6'd5:  r = 20'd209716;
         6'd6:  r = 20'd174763;
         6'd7:  r = 20'd149797;
         6'd8:  r = 20'd131072;
         6'd9:  r = 20'd116509;
         6'd10: r = 20'd104858;
         6'd11: r = 20'd95326;
         6'd12: r = 20'd87382;
         6'd13: r = 20'd80660;
         6'd14: r = 20'd74899;
         6'd15: r = 20'd69906;
         6'd16: r = 20'd65536;
         6'd17: r = 20'd61681;
         6'd18: r = 20'd58255;
         6'd19: r = 20'd55189;
         6'd20: r = 20'd52429;
         6'd21: r = 20'd49933;
         6'd22: r = 20'd47663;
         6'd23: r = 20'd45591;
         6'd24: r = 20'd43691;
         6'd25: r = 20'd41944;
         6'd26: r = 20'd40330;
         6'd27: r = 20'd38837;
         6'd28: r = 20'd37450;
         6'd29: r = 20'd36158;
         6'd30: r = 20'd34953;
         6'd31: r = 20'd33826;
         6'd32: r = 20'd32768;
         6'd33: r = 20'd31776;
         6'd34: r = 20'd30841;
         6'd35: r = 20'd29960;
         6'd36: r = 20'd29128;
         6'd37: r = 20'd28340;
         6'd38: r = 20'd27595;
         6'd39: r = 20'd26887;
         6'd40: r = 20'd26215;
         6'd41: r = 20'd25576;
         6'd42: r = 20'd24967;
         6'd43: r = 20'd24386;
         6'd44: r = 20'd23832;
         6'd45: r = 20'd23302;
         6'd46: r = 20'd22796;
         6'd47: r = 20'd22311;
         6'd48: r = 20'd21846;
         6'd49: r = 20'd21400;
         6'd50: r = 20'd20972;
         6'd51: r = 20'd20561;
         6'd52: r = 20'd20165;
         6'd53: r = 20'd19785;
         6'd54: r = 20'd19419;
         6'd55: r = 20'd19066;
         6'd56: r = 20'd18725;
         6'd57: r = 20'd18397;
         6'd58: r = 20'd18079;
         6'd59: r = 20'd17773;
         6'd60: r = 20'd17477;
         6'd61: r = 20'd17190;
         6'd62: r = 20'd16913;
         6'd63: r = 20'd16645;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/bma_if.sv]
// Valid/ready channel interfaces of the mosaic block averager: pixels in, block results out.
// No package dependency; payload widths are fixed by the channel definitions.
interface bma_pixel_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bma_block_if;
   logic       valid;
   logic       ready;
   logic [7:0] block_column;
   logic [6:0] block_row;
   logic [7:0] avg_red;
   logic [7:0] avg_green;
   logic [7:0] avg_blue;
   logic       frame_done;

   modport source (output valid, output block_column, output block_row, output avg_red,
                   output avg_green, output avg_blue, output frame_done, input ready);
   modport sink   (input valid, input block_column, input block_row, input avg_red,
                   input avg_green, input avg_blue, input frame_done, output ready);
endinterface

[rtl/core/bma_avg_pipe.sv]
// Averaging pipeline: divides block sums by the qualifying count and saturates.
// Depends on bma_pkg for the job and result types and the reciprocal table.
module bma_avg_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  bma_pkg::bma_job_type    job_data,
   output logic                    res_valid,
   input  logic                    res_ready,
   output bma_pkg::bma_result_type res_data
);
   import bma_pkg::*;

   logic           a_valid_ff, a_valid_in;
   bma_job_type    a_job_ff;
   logic           b_valid_ff, b_valid_in;
   bma_job_type    b_job_ff;
   logic [PROD_W-1:0] b_prod_ff [CHANNELS];
   logic [PROD_W-1:0] prod_in [CHANNELS];
   logic           res_valid_ff, res_valid_in;
   bma_result_type res_data_ff, res_data_in;
   logic           a_ready, b_ready, c_ready;
   logic [RECIP_W-1:0] recip;
   logic [SUM_W-1:0]   quot [CHANNELS];
   logic [PIX_W-1:0]   avg [CHANNELS];
   logic               raw;

   // Each stage moves on when the stage after it is empty or moving.
   assign c_ready   = !res_valid_ff || res_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign job_ready = a_ready;

   always_comb begin
      a_valid_in   = a_ready ? job_valid : a_valid_ff;
      b_valid_in   = b_ready ? a_valid_ff : b_valid_ff;
      res_valid_in = c_ready ? b_valid_ff : res_valid_ff;
   end

   // Stage B: one multiply per channel by the reciprocal of the count.
   always_comb begin
      recip = bma_recip(a_job_ff.acc.count);
      for (int i = 0; i < CHANNELS; i++) begin
         prod_in[i] = PROD_W'(a_job_ff.acc.sum[i]) * PROD_W'(recip);
      end
   end

   // Stage C: pick quotient or raw sum, then clamp to the pixel range.
   always_comb begin
      raw = b_job_ff.acc.count < CNT_W'(MIN_BLOCK);
      for (int i = 0; i < CHANNELS; i++) begin
         quot[i] = raw ? b_job_ff.acc.sum[i] : b_prod_ff[i][RECIP_SHIFT +: SUM_W];
         avg[i]  = (quot[i] > SUM_W'(AVG_MAX)) ? PIX_W'(AVG_MAX) : quot[i][PIX_W-1:0];
      end
      res_data_in.block_column = b_job_ff.block_column;
      res_data_in.block_row    = b_job_ff.block_row;
      res_data_in.avg_red      = avg[CH_RED];
      res_data_in.avg_green    = avg[CH_GREEN];
      res_data_in.avg_blue     = avg[CH_BLUE];
      res_data_in.frame_done   = b_job_ff.frame_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && job_valid) begin
         a_job_ff <= job_data;
      end
      if (b_ready && a_valid_ff) begin
         b_job_ff <= a_job_ff;
         for (int i = 0; i < CHANNELS; i++) begin
            b_prod_ff[i] <= prod_in[i];
         end
      end
      if (c_ready && b_valid_ff) begin
         res_data_ff <= res_data_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;

endmodule

[rtl/core/block_mosaic_averager.sv]
// Mosaic block averager top level: raster position tracking, block-column accumulator memory.
// Depends on bma_pkg, the bma_pixel_if / bma_block_if channels and bma_avg_pipe.
// Throughput: one pixel transaction per clock, set by the single read-modify-write of the
//   block-column entry in the accumulator memory; only a stalled result channel slows it.
// Result path: a block result passes the read-modify-write register and stages A, B and C.
// Reset (synchronous, active high) restores the default registers, the raster position and
//   the memory fill count, which makes every accumulator entry read as zero at once.
module block_mosaic_averager #(
   parameter int MAX_WIDTH  = bma_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bma_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   bma_pixel_if.sink                      req_chan,
   bma_block_if.source                    rsp_chan,
   input  logic                           csr_we,
   input  logic [bma_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bma_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bma_pkg::*;

   // One memory entry per possible block column (the smallest block is two pixels wide).
   localparam int COL_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int IDX_W     = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
   localparam int FILL_W    = $clog2(COL_DEPTH + 1);

   // Registers hold the effective (clamped) sizes minus one, computed when written.
   localparam int W_RESET_EFF = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam int H_RESET_EFF = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : FRAME_HEIGHT_RESET;
   localparam logic [BLOCK_SIZE_W-1:0]   BS_M1_RESET = BLOCK_SIZE_W'(BLOCK_SIZE_RESET - 1);
   localparam logic [FRAME_WIDTH_W-1:0]  W_M1_RESET  = FRAME_WIDTH_W'(W_RESET_EFF - 1);
   localparam logic [FRAME_HEIGHT_W-1:0] H_M1_RESET  = FRAME_HEIGHT_W'(H_RESET_EFF - 1);

   // Configuration.
   logic [BLOCK_SIZE_W-1:0]   bs_m1_ff, bs_m1_in;
   logic [FRAME_WIDTH_W-1:0]  w_m1_ff, w_m1_in;
   logic [FRAME_HEIGHT_W-1:0] h_m1_ff, h_m1_in;
   logic [BLOCK_SIZE_W-1:0]   bs_v;
   logic [FRAME_WIDTH_W-1:0]  w_v;
   logic [FRAME_HEIGHT_W-1:0] h_v;
   logic                      csr_hit;

   // Raster position.
   logic [FRAME_WIDTH_W-1:0]  pix_col_ff, pix_col_in;
   logic [FRAME_HEIGHT_W-1:0] pix_row_ff, pix_row_in;
   logic [BLOCK_SIZE_W-1:0]   col_in_blk_ff, col_in_blk_in;
   logic [BLOCK_SIZE_W-1:0]   row_in_blk_ff, row_in_blk_in;
   logic [IDX_W-1:0]          blk_col_ff, blk_col_in;
   logic [BLOCK_ROW_W-1:0]    blk_row_ff, blk_row_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      last_col, last_row, col_wrap, row_wrap;
   logic                      blk_emit, entry_live;

   // Read-modify-write stage.
   logic                      req_accept;
   logic                      s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]          s1_pix_ff [CHANNELS];
   logic [IDX_W-1:0]          s1_idx_ff;
   logic [BLOCK_ROW_W-1:0]    s1_brow_ff;
   logic                      s1_emit_ff;
   logic                      s1_done_ff;
   logic                      s1_live_ff;
   logic                      s1_fwd_ff;
   bma_acc_type               s1_fwd_data_ff;
   logic                      s1_advance;
   logic                      fwd_in;
   logic                      qualify;
   bma_acc_type               rd_data_ff;
   bma_acc_type               old_acc, new_acc, wr_data;
   bma_acc_type               acc_mem [COL_DEPTH];

   // Averaging pipeline hookup.
   logic                      job_valid, job_ready;
   bma_job_type               job_data;
   logic                      res_valid;
   bma_result_type            res_data;

   // ---------------------------------------------------------------------------------------
   // Configuration writes. Any write to a known register restarts the frame.
   // Out-of-range sizes are folded here, so the datapath only sees legal values.
   // ---------------------------------------------------------------------------------------
   assign bs_v = csr_wdata[BLOCK_SIZE_W-1:0];
   assign w_v  = csr_wdata[FRAME_WIDTH_W-1:0];
   assign h_v  = csr_wdata[FRAME_HEIGHT_W-1:0];

   always_comb begin
      bs_m1_in = bs_m1_ff;
      w_m1_in  = w_m1_ff;
      h_m1_in  = h_m1_ff;
      csr_hit  = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_SIZE: begin
               csr_hit  = 1'b1;
               bs_m1_in = (bs_v < BLOCK_SIZE_W'(MIN_BLOCK)) ? BLOCK_SIZE_W'(MIN_BLOCK - 1)
                                                            : bs_v - BLOCK_SIZE_W'(1);
            end
            CSR_FRAME_WIDTH: begin
               csr_hit = 1'b1;
               if (w_v == '0) begin
                  w_m1_in = '0;
               end else if (int'(w_v) > MAX_WIDTH) begin
                  w_m1_in = FRAME_WIDTH_W'(MAX_WIDTH - 1);
               end else begin
                  w_m1_in = w_v - FRAME_WIDTH_W'(1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               csr_hit = 1'b1;
               if (h_v == '0) begin
                  h_m1_in = '0;
               end else if (int'(h_v) > MAX_HEIGHT) begin
                  h_m1_in = FRAME_HEIGHT_W'(MAX_HEIGHT - 1);
               end else begin
                  h_m1_in = h_v - FRAME_HEIGHT_W'(1);
               end
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Raster position. The block column and row are counted directly alongside the
   // in-block offsets, so no division by the block size is needed.
   // ---------------------------------------------------------------------------------------
   assign last_col   = pix_col_ff >= w_m1_ff;
   assign last_row   = pix_row_ff >= h_m1_ff;
   assign col_wrap   = col_in_blk_ff >= bs_m1_ff;
   assign row_wrap   = row_in_blk_ff >= bs_m1_ff;
   assign blk_emit   = (col_wrap || last_col) && (row_wrap || last_row);

   // The first row of blocks touches the block columns in increasing order, one new column
   // at a time. Entries at or above the fill count have never been written since the last
   // restart and read as zero. At the end of a frame every used entry has been cleared by
   // its final block, so the fill count only needs resetting on a restart.
   assign entry_live = FILL_W'(blk_col_ff) < fill_ff;

   assign req_accept = req_chan.valid && req_chan.ready;

   always_comb begin
      pix_col_in    = pix_col_ff;
      pix_row_in    = pix_row_ff;
      col_in_blk_in = col_in_blk_ff;
      row_in_blk_in = row_in_blk_ff;
      blk_col_in    = blk_col_ff;
      blk_row_in    = blk_row_ff;
      fill_in       = fill_ff;
      if (csr_hit) begin
         pix_col_in    = '0;
         pix_row_in    = '0;
         col_in_blk_in = '0;
         row_in_blk_in = '0;
         blk_col_in    = '0;
         blk_row_in    = '0;
         fill_in       = '0;
      end else if (req_accept) begin
         if (!entry_live) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         if (last_col) begin
            pix_col_in    = '0;
            col_in_blk_in = '0;
            blk_col_in    = '0;
            if (last_row) begin
               pix_row_in    = '0;
               row_in_blk_in = '0;
               blk_row_in    = '0;
            end else begin
               pix_row_in = pix_row_ff + FRAME_HEIGHT_W'(1);
               if (row_wrap) begin
                  row_in_blk_in = '0;
                  blk_row_in    = blk_row_ff + BLOCK_ROW_W'(1);
               end else begin
                  row_in_blk_in = row_in_blk_ff + BLOCK_SIZE_W'(1);
               end
            end
         end else begin
            pix_col_in = pix_col_ff + FRAME_WIDTH_W'(1);
            if (col_wrap) begin
               col_in_blk_in = '0;
               blk_col_in    = blk_col_ff + IDX_W'(1);
            end else begin
               col_in_blk_in = col_in_blk_ff + BLOCK_SIZE_W'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Read-modify-write. The memory read is issued with the pixel transaction and its data is
   // registered with the stage, which adds the pixel and writes the entry back as it advances.
   // If the previous pixel wrote the same entry in the cycle this one was read, the read
   // returned the old word, so the written word is forwarded instead.
   // ---------------------------------------------------------------------------------------
   assign s1_advance     = s1_valid_ff && (!s1_emit_ff || job_ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   assign fwd_in = s1_advance && req_accept && (s1_idx_ff == blk_col_ff);

   always_comb begin
      if (s1_fwd_ff) begin
         old_acc = s1_fwd_data_ff;
      end else if (s1_live_ff) begin
         old_acc = rd_data_ff;
      end else begin
         old_acc = '0;
      end
      // A pixel counts toward the divisor only when all three channels are nonzero;
      // every pixel adds to the sums.
      qualify = (s1_pix_ff[CH_RED] != '0) && (s1_pix_ff[CH_GREEN] != '0)
                && (s1_pix_ff[CH_BLUE] != '0);
      for (int i = 0; i < CHANNELS; i++) begin
         new_acc.sum[i] = old_acc.sum[i] + SUM_W'(s1_pix_ff[i]);
      end
      new_acc.count = old_acc.count + CNT_W'(qualify);
      // A completed block hands its totals on and leaves the entry cleared.
      wr_data = s1_emit_ff ? '0 : new_acc;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         acc_mem[s1_idx_ff] <= wr_data;
      end
      if (req_accept) begin
         rd_data_ff <= acc_mem[blk_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff[CH_RED]   <= req_chan.red;
         s1_pix_ff[CH_GREEN] <= req_chan.green;
         s1_pix_ff[CH_BLUE]  <= req_chan.blue;
         s1_idx_ff           <= blk_col_ff;
         s1_brow_ff          <= blk_row_ff;
         s1_emit_ff          <= blk_emit;
         s1_done_ff          <= last_col && last_row;
         s1_live_ff          <= entry_live;
         s1_fwd_ff           <= fwd_in;
         s1_fwd_data_ff      <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_m1_ff      <= BS_M1_RESET;
         w_m1_ff       <= W_M1_RESET;
         h_m1_ff       <= H_M1_RESET;
         pix_col_ff    <= '0;
         pix_row_ff    <= '0;
         col_in_blk_ff <= '0;
         row_in_blk_ff <= '0;
         blk_col_ff    <= '0;
         blk_row_ff    <= '0;
         fill_ff       <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         bs_m1_ff      <= bs_m1_in;
         w_m1_ff       <= w_m1_in;
         h_m1_ff       <= h_m1_in;
         pix_col_ff    <= pix_col_in;
         pix_row_ff    <= pix_row_in;
         col_in_blk_ff <= col_in_blk_in;
         row_in_blk_ff <= row_in_blk_in;
         blk_col_ff    <= blk_col_in;
         blk_row_ff    <= blk_row_in;
         fill_ff       <= fill_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Completed blocks go to the averaging pipeline, whose last register drives the result
   // channel directly.
   // ---------------------------------------------------------------------------------------
   assign job_valid             = s1_valid_ff && s1_emit_ff;
   assign job_data.block_column = BLOCK_COLUMN_W'(s1_idx_ff);
   assign job_data.block_row    = s1_brow_ff;
   assign job_data.frame_done   = s1_done_ff;
   assign job_data.acc          = new_acc;

   bma_avg_pipe u_avg_pipe (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .res_valid (res_valid),
      .res_ready (rsp_chan.ready),
      .res_data  (res_data)
   );

   assign rsp_chan.valid        = res_valid;
   assign rsp_chan.block_column = res_data.block_column;
   assign rsp_chan.block_row    = res_data.block_row;
   assign rsp_chan.avg_red      = res_data.avg_red;
   assign rsp_chan.avg_green    = res_data.avg_green;
   assign rsp_chan.avg_blue     = res_data.avg_blue;
   assign rsp_chan.frame_done   = res_data.frame_done;

   // ---------------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------------

   // A pixel never addresses a block column beyond the first unwritten entry.
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (FILL_W'(blk_col_ff) <= fill_ff))
      else $error("block column ran ahead of the memory fill count");

   // The in-block offsets stay inside the current block size.
   a_block_offsets: assert property (@(posedge clock) disable iff (reset)
      (col_in_blk_ff <= bs_m1_ff) && (row_in_blk_ff <= bs_m1_ff))
      else $error("in-block offset beyond block size");

   // The raster position stays inside the frame.
   a_raster_bounds: assert property (@(posedge clock) disable iff (reset)
      (pix_col_ff <= w_m1_ff) && (pix_row_ff <= h_m1_ff))
      else $error("raster position outside frame");

   // A forwarded word is only ever used by an entry that was live when it was read.
   a_forward_live: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> s1_live_ff)
      else $error("forwarding into an entry that reads as cleared");

endmodule
